>>> hdl/vlvc_pkg.sv
// ----------------------------------------------------------------------------
// vlvc_pkg
// Shared types, widths and codes for the velocity limit violation cost block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vlvc_pkg;

  // Build-time exponent applied to the weighted violation sum (1 to 4).
  localparam int SumExponent = 1;
  localparam int PowCntW     = $clog2(SumExponent + 1);

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  localparam int AccW  = 48;  // violation sum, Q32.16
  localparam int WsumW = 35;  // weighted violation, Q12.20 with headroom
  localparam int LinVW = 18;
  localparam int AngVW = 16;
  localparam int MulAW = 36;  // shared multiplier operand widths
  localparam int MulBW = 18;
  localparam int MulPW = MulAW + MulBW;
  localparam int PartW = 48;
  localparam int CostW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LINEAR_MIN     = 3'd0,
    CFG_LINEAR_MAX     = 3'd1,
    CFG_ANGULAR_LIMIT  = 3'd2,
    CFG_LINEAR_WEIGHT  = 3'd3,
    CFG_ANGULAR_WEIGHT = 3'd4,
    CFG_STEP_TIME      = 3'd5,
    CFG_OVERALL_WEIGHT = 3'd6,
    CFG_BAD_STATE_COST = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] linear_min;
    logic signed [15:0] linear_max;
    logic [14:0]        angular_limit;
    logic [15:0]        linear_weight;
    logic [15:0]        angular_weight;
    logic [15:0]        step_time;
    logic [15:0]        overall_weight;
    logic [CostW-1:0]   bad_state_cost;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] linear_speed;
    logic signed [15:0] turn_rate;
    logic               sample_bad;
    logic               last_step;
    logic [CostW-1:0]   prior_cost;
  } in_item_t;

  typedef struct packed {
    logic [CostW-1:0] new_cost;
    logic             was_bad;
    logic             saturated;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LIN,
    S_ANG,
    S_DT,
    S_FLO,
    S_FHI,
    S_PLO,
    S_PHI,
    S_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LIN,
    OP_ANG,
    OP_DT,
    OP_FLO,
    OP_FHI,
    OP_PLO,
    OP_PHI,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic   capture;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic bad_seen;
    logic last_step;
    logic out_free;
  } dp_sts_t;

endpackage

>>> hdl/velocity_limit_violation_cost.sv
// ----------------------------------------------------------------------------
// velocity_limit_violation_cost
// Scores a trajectory by how far its velocities leave the configured limits.
// Each beat on the input carries one time step of a trajectory. The block
// weighs the linear and angular limit violations of the step, scales them by
// the step length and adds them to a saturating 48-bit sum. A step flagged as
// invalid marks the trajectory bad, and it and every later step of that
// trajectory add nothing. The beat marked as the last step produces one result
// beat: the prior cost plus either the invalid-state cost, or the overall
// weight times the sum, that product raised to SumExponent, all saturated
// to 32 bits. All products come from one shared 36 x 18 multiplier, which
// sets the rate. An ordinary step passes through S_LIN, S_ANG and S_DT, and
// the next step can be taken in S_DT; after idle it is first taken in S_IDLE.
// After an invalid sample, later steps are taken in S_LIN with no product. A
// good last step runs on through S_FLO, S_FHI, an S_PLO and S_PHI pair per
// further power, and S_OUT; a bad one goes from S_LIN to S_OUT.
// A finished result waits in the output register without holding up the
// ordinary steps of the next trajectory; only the next last step waits, for as
// long as the receiver leaves the earlier result in place. Configuration
// registers must be written only while the block idles; it is not enforced.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module velocity_limit_violation_cost (
  input  logic                          clk,
  input  logic                          rst_n,
  // Time step input.
  input  logic                          in_valid,
  output logic                          in_ready,
  input  vlvc_pkg::in_item_t            in_item,
  // Result output, one beat per trajectory.
  output logic                          out_valid,
  input  logic                          out_ready,
  output vlvc_pkg::out_item_t           out_item,
  // Configuration write port.
  input  logic                          cfg_we,
  input  logic [vlvc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [vlvc_pkg::CfgDataW-1:0] cfg_wdata
);

  vlvc_pkg::cfg_t    cfg;
  vlvc_pkg::dp_cmd_t cmd;
  vlvc_pkg::dp_sts_t sts;

  // Register file for the limits, weights, step length and invalid cost.
  vlvc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The sequencer decides which multiplier operation runs in each cycle and
  // when an input beat may be taken.
  vlvc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the trajectory state, the multiplier and the result
  // register that decouples the output from the sequencer.
  vlvc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .in_item   (in_item),
    .out_ready (out_ready),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

>>> hdl/vlvc_cfg.sv
// ----------------------------------------------------------------------------
// vlvc_cfg
// Configuration register file with a plain indexed write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vlvc_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [vlvc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [vlvc_pkg::CfgDataW-1:0] cfg_wdata,
  output vlvc_pkg::cfg_t                cfg
);

  vlvc_pkg::cfg_t cfg_r;
  vlvc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (vlvc_pkg::cfg_idx_t'(cfg_index))
        vlvc_pkg::CFG_LINEAR_MIN:     cfg_nxt.linear_min     = cfg_wdata[15:0];
        vlvc_pkg::CFG_LINEAR_MAX:     cfg_nxt.linear_max     = cfg_wdata[15:0];
        vlvc_pkg::CFG_ANGULAR_LIMIT:  cfg_nxt.angular_limit  = cfg_wdata[14:0];
        vlvc_pkg::CFG_LINEAR_WEIGHT:  cfg_nxt.linear_weight  = cfg_wdata[15:0];
        vlvc_pkg::CFG_ANGULAR_WEIGHT: cfg_nxt.angular_weight = cfg_wdata[15:0];
        vlvc_pkg::CFG_STEP_TIME:      cfg_nxt.step_time      = cfg_wdata[15:0];
        vlvc_pkg::CFG_OVERALL_WEIGHT: cfg_nxt.overall_weight = cfg_wdata[15:0];
        vlvc_pkg::CFG_BAD_STATE_COST: cfg_nxt.bad_state_cost = cfg_wdata[31:0];
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.linear_min     <= 16'sd0;
      cfg_r.linear_max     <= 16'sd4096;
      cfg_r.angular_limit  <= 15'd4096;
      cfg_r.linear_weight  <= 16'd256;
      cfg_r.angular_weight <= 16'd256;
      cfg_r.step_time      <= 16'd3277;
      cfg_r.overall_weight <= 16'd256;
      cfg_r.bad_state_cost <= 32'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hdl/vlvc_ctrl.sv
// ----------------------------------------------------------------------------
// vlvc_ctrl
// Sequencer that steps the shared multiplier through each time step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vlvc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  vlvc_pkg::dp_sts_t sts,
  output vlvc_pkg::dp_cmd_t cmd
);

  vlvc_pkg::state_t                 state_r;
  vlvc_pkg::state_t                 state_nxt;
  logic [vlvc_pkg::PowCntW-1:0]     pow_cnt_r;
  logic [vlvc_pkg::PowCntW-1:0]     pow_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= vlvc_pkg::S_IDLE;
      pow_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      pow_cnt_r <= pow_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    pow_cnt_nxt = pow_cnt_r;
    in_ready    = 1'b0;
    cmd.op      = vlvc_pkg::OP_NONE;
    unique case (state_r)
      vlvc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = vlvc_pkg::S_LIN;
        end
      end
      vlvc_pkg::S_LIN: begin
        // Steps after an invalid sample contribute nothing.
        if (sts.bad_seen) begin
          if (sts.last_step) begin
            state_nxt = vlvc_pkg::S_OUT;
          end else begin
            in_ready  = 1'b1;
            state_nxt = in_valid ? vlvc_pkg::S_LIN : vlvc_pkg::S_IDLE;
          end
        end else begin
          cmd.op    = vlvc_pkg::OP_LIN;
          state_nxt = vlvc_pkg::S_ANG;
        end
      end
      vlvc_pkg::S_ANG: begin
        cmd.op    = vlvc_pkg::OP_ANG;
        state_nxt = vlvc_pkg::S_DT;
      end
      vlvc_pkg::S_DT: begin
        cmd.op = vlvc_pkg::OP_DT;
        if (sts.last_step) begin
          state_nxt = vlvc_pkg::S_FLO;
        end else begin
          in_ready  = 1'b1;
          state_nxt = in_valid ? vlvc_pkg::S_LIN : vlvc_pkg::S_IDLE;
        end
      end
      vlvc_pkg::S_FLO: begin
        cmd.op    = vlvc_pkg::OP_FLO;
        state_nxt = vlvc_pkg::S_FHI;
      end
      vlvc_pkg::S_FHI: begin
        cmd.op      = vlvc_pkg::OP_FHI;
        pow_cnt_nxt = vlvc_pkg::PowCntW'(1);
        state_nxt   = (vlvc_pkg::SumExponent > 1) ? vlvc_pkg::S_PLO : vlvc_pkg::S_OUT;
      end
      vlvc_pkg::S_PLO: begin
        cmd.op    = vlvc_pkg::OP_PLO;
        state_nxt = vlvc_pkg::S_PHI;
      end
      vlvc_pkg::S_PHI: begin
        cmd.op      = vlvc_pkg::OP_PHI;
        pow_cnt_nxt = pow_cnt_r + vlvc_pkg::PowCntW'(1);
        state_nxt   = (pow_cnt_nxt < vlvc_pkg::PowCntW'(vlvc_pkg::SumExponent)) ?
                      vlvc_pkg::S_PLO : vlvc_pkg::S_OUT;
      end
      vlvc_pkg::S_OUT: begin
        if (sts.out_free) begin
          cmd.op    = vlvc_pkg::OP_OUT;
          state_nxt = vlvc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = vlvc_pkg::S_IDLE;
      end
    endcase
    cmd.capture = in_valid && in_ready;
  end

endmodule

>>> hdl/vlvc_dp.sv
// ----------------------------------------------------------------------------
// vlvc_dp
// Datapath: violation terms, shared multiplier, accumulator and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vlvc_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  vlvc_pkg::cfg_t      cfg,
  input  vlvc_pkg::dp_cmd_t   cmd,
  input  vlvc_pkg::in_item_t  in_item,
  input  logic                out_ready,
  output vlvc_pkg::dp_sts_t   sts,
  output logic                out_valid,
  output vlvc_pkg::out_item_t out_item
);

  localparam int AccW  = vlvc_pkg::AccW;
  localparam int CostW = vlvc_pkg::CostW;

  // Item and working registers.
  vlvc_pkg::in_item_t          item_r, item_nxt;
  logic [vlvc_pkg::WsumW-1:0]  wsum_r, wsum_nxt;
  logic [vlvc_pkg::PartW-1:0]  part_r, part_nxt;
  logic [CostW-1:0]            base_r, base_nxt;
  logic [CostW-1:0]            fin_r, fin_nxt;
  vlvc_pkg::out_item_t         out_item_r, out_item_nxt;

  // Per-trajectory and handshake state.
  logic [AccW-1:0] vsum_r, vsum_nxt;
  logic            bad_seen_r, bad_seen_nxt;
  logic            clip_r, clip_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Violation terms.
  logic signed [17:0]          vx_s, vmax_s, vmin_s, above_s, below_s;
  logic signed [16:0]          wz_s, awz_s, ang_s;
  logic [vlvc_pkg::LinVW-1:0]  lin_v;
  logic [vlvc_pkg::AngVW-1:0]  ang_v;

  // Shared multiplier.
  logic [vlvc_pkg::MulAW-1:0]  mul_a;
  logic [vlvc_pkg::MulBW-1:0]  mul_b;
  logic [vlvc_pkg::MulPW-1:0]  prod;

  logic [AccW:0]      acc_sum;
  logic [63:0]        scale_full;
  logic [55:0]        scale_q;
  logic [AccW:0]      pow_sum;
  logic [CostW:0]     fin_sum;
  logic [CostW-1:0]   addend;

  always_comb begin
    vx_s    = {{2{item_r.linear_speed[15]}}, item_r.linear_speed};
    vmax_s  = {{2{cfg.linear_max[15]}}, cfg.linear_max};
    vmin_s  = {{2{cfg.linear_min[15]}}, cfg.linear_min};
    above_s = vx_s - vmax_s;
    below_s = vmin_s - vx_s;
    lin_v   = ((!above_s[17] && (above_s != '0)) ? {1'b0, above_s[16:0]} : '0)
            + ((!below_s[17] && (below_s != '0)) ? {1'b0, below_s[16:0]} : '0);
    wz_s    = {item_r.turn_rate[15], item_r.turn_rate};
    awz_s   = wz_s[16] ? -wz_s : wz_s;
    ang_s   = awz_s - {2'b00, cfg.angular_limit};
    ang_v   = (!ang_s[16] && (ang_s != '0)) ? ang_s[15:0] : '0;
  end

  always_comb begin
    unique case (cmd.op)
      vlvc_pkg::OP_LIN: begin
        mul_a = vlvc_pkg::MulAW'(cfg.linear_weight);
        mul_b = lin_v;
      end
      vlvc_pkg::OP_ANG: begin
        mul_a = vlvc_pkg::MulAW'(cfg.angular_weight);
        mul_b = vlvc_pkg::MulBW'(ang_v);
      end
      vlvc_pkg::OP_DT: begin
        mul_a = vlvc_pkg::MulAW'(wsum_r);
        mul_b = vlvc_pkg::MulBW'(cfg.step_time);
      end
      vlvc_pkg::OP_FLO: begin
        mul_a = vlvc_pkg::MulAW'(vsum_r[23:0]);
        mul_b = vlvc_pkg::MulBW'(cfg.overall_weight);
      end
      vlvc_pkg::OP_FHI: begin
        mul_a = vlvc_pkg::MulAW'(vsum_r[47:24]);
        mul_b = vlvc_pkg::MulBW'(cfg.overall_weight);
      end
      vlvc_pkg::OP_PLO: begin
        mul_a = vlvc_pkg::MulAW'(fin_r);
        mul_b = vlvc_pkg::MulBW'(base_r[15:0]);
      end
      vlvc_pkg::OP_PHI: begin
        mul_a = vlvc_pkg::MulAW'(fin_r);
        mul_b = vlvc_pkg::MulBW'(base_r[31:16]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    // Step increment lands in Q32.16 after dropping 20 fraction bits.
    acc_sum    = {1'b0, vsum_r} + (AccW + 1)'(prod[53:20]);
    // Overall weight times the sum, rebuilt from its two 24-bit halves.
    scale_full = {prod[39:0], 24'd0} + {24'd0, part_r[39:0]};
    scale_q    = scale_full[63:8];
    // One power step: (fin * base) >> 16 from the two 16-bit halves of base.
    pow_sum    = {1'b0, prod[47:0]} + {17'd0, part_r[47:16]};
    addend     = bad_seen_r ? cfg.bad_state_cost : fin_r;
    fin_sum    = {1'b0, item_r.prior_cost} + {1'b0, addend};
  end

  always_comb begin
    item_nxt      = item_r;
    wsum_nxt      = wsum_r;
    part_nxt      = part_r;
    base_nxt      = base_r;
    fin_nxt       = fin_r;
    out_item_nxt  = out_item_r;
    vsum_nxt      = vsum_r;
    bad_seen_nxt  = bad_seen_r;
    clip_nxt      = clip_r;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (cmd.op)
      vlvc_pkg::OP_LIN: wsum_nxt = prod[vlvc_pkg::WsumW-1:0];
      vlvc_pkg::OP_ANG: wsum_nxt = wsum_r + prod[vlvc_pkg::WsumW-1:0];
      vlvc_pkg::OP_DT: begin
        if (acc_sum[AccW]) begin
          vsum_nxt = '1;
          clip_nxt = 1'b1;
        end else begin
          vsum_nxt = acc_sum[AccW-1:0];
        end
      end
      vlvc_pkg::OP_FLO: part_nxt = prod[vlvc_pkg::PartW-1:0];
      vlvc_pkg::OP_FHI: begin
        if (|scale_q[55:32]) begin
          base_nxt = '1;
          clip_nxt = 1'b1;
        end else begin
          base_nxt = scale_q[31:0];
        end
        fin_nxt = base_nxt;
      end
      vlvc_pkg::OP_PLO: part_nxt = prod[vlvc_pkg::PartW-1:0];
      vlvc_pkg::OP_PHI: begin
        if (|pow_sum[AccW:CostW]) begin
          fin_nxt  = '1;
          clip_nxt = 1'b1;
        end else begin
          fin_nxt = pow_sum[CostW-1:0];
        end
      end
      vlvc_pkg::OP_OUT: begin
        out_item_nxt.new_cost  = fin_sum[CostW] ? '1 : fin_sum[CostW-1:0];
        out_item_nxt.was_bad   = bad_seen_r;
        // A bad trajectory reports only the clip of its own final addition.
        out_item_nxt.saturated = fin_sum[CostW] || (!bad_seen_r && clip_r);
        out_valid_nxt          = 1'b1;
        vsum_nxt               = '0;
        bad_seen_nxt           = 1'b0;
        clip_nxt               = 1'b0;
      end
      default: begin
      end
    endcase

    if (cmd.capture) begin
      item_nxt     = in_item;
      bad_seen_nxt = bad_seen_nxt || in_item.sample_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vsum_r      <= '0;
      bad_seen_r  <= 1'b0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vsum_r      <= vsum_nxt;
      bad_seen_r  <= bad_seen_nxt;
      clip_r      <= clip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    wsum_r     <= wsum_nxt;
    part_r     <= part_nxt;
    base_r     <= base_nxt;
    fin_r      <= fin_nxt;
    out_item_r <= out_item_nxt;
  end

  assign sts.bad_seen  = bad_seen_r;
  assign sts.last_step = item_r.last_step;
  assign sts.out_free  = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_item      = out_item_r;

endmodule

>>> hdl/vlvc_chk.sv
// ----------------------------------------------------------------------------
// vlvc_chk
// Port-level checks for the velocity limit violation cost block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vlvc_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input vlvc_pkg::in_item_t            in_item,
  input logic                          out_valid,
  input logic                          out_ready,
  input vlvc_pkg::out_item_t           out_item
);

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat present after reset");

  // A waiting result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result beat changed while stalled");

  // Taking the last step of a trajectory closes the input.
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_item.last_step |=> !in_ready)
    else $error("input open right after a last step");

  // A result appears only out of the finishing step, never while input is open.
  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result beat appeared while input was open");

endmodule

bind velocity_limit_violation_cost vlvc_chk u_vlvc_chk (.*);
